### hdl/sha_pkg.sv
// SHA-256 hasher package: round constants, initial hash values, a rotate helper function.
// No dependencies; imported by every module of the hasher.
`default_nettype none
package sha_pkg;

	localparam int WordW = 32;
	localparam int FifoDepthDef = 4;

	typedef struct packed {
		logic [31:0] data;
		logic [2:0]  count;
		logic        last;
	} item_t;

	localparam logic [31:0] InitH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] PadLimit = 6'd55;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage
`default_nettype wire

### hdl/sha_fifo.sv
// Short item queue between the front end and the compression engine.
// Depends on sha_pkg for the item type.
`default_nettype none
module sha_fifo
	import sha_pkg::*;
#(
	parameter int Depth = FifoDepthDef
) (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   wr_valid,
	output logic  wr_ready,
	input  item_t wr_item,
	output logic  rd_valid,
	input  wire   rd_ready,
	output item_t rd_item
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	item_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic do_wr, do_rd;

	assign wr_ready = (cnt_q != (AW+1)'(Depth));
	assign rd_valid = (cnt_q != '0);
	assign rd_item  = mem_q[rp_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) mem_q[wp_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) wp_q <= (wp_q == AW'(Depth - 1)) ? '0 : wp_q + 1'b1;
			if (do_rd) rp_q <= (rp_q == AW'(Depth - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(do_wr) - (AW+1)'(do_rd);
		end
	end
endmodule
`default_nettype wire

### hdl/sha_core.sv
// Back end: byte packing, padding, 64-round compression and digest output.
// Depends on sha_pkg for constants, item type and rotate function.
`default_nettype none
module sha_core
	import sha_pkg::*;
(
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  item_t       in_item,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [31:0] out_word,
	output logic        out_last
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_BYTES, ST_PAD, ST_ROUND, ST_FINISH, ST_OUT
	} state_t;

	state_t state_q, ret_q;
	logic [31:0] buf_q [16];
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [63:0] len_q;
	logic [5:0]  fill_q;
	logic [31:0] word_q;
	logic [2:0]  cnt_q, bi_q;
	logic        last_q, pad_first_q, extra_q;
	logic [5:0]  rnd_q;
	logic [2:0]  oi_q;
	logic [31:0] ow_q;
	logic        olast_q, ovalid_q;

	// padding/put_byte helpers
	logic [7:0]  cur_byte;
	logic [3:0]  bidx;
	logic [4:0]  bsh;
	logic [31:0] t1, t2, wn, s0, s1, wcur;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = ovalid_q;
	assign out_word  = ow_q;
	assign out_last  = olast_q;
	assign bidx = fill_q[5:2];
	// byte lane shift: (3 - lane) * 8
	assign bsh  = {~fill_q[1:0], 3'b000};
	assign cur_byte = word_q[31 - 8*bi_q -: 8];

	assign wcur = w_q[0];
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wn = w_q[0] + s0 + w_q[9] + s1;
	assign t1 = v_q[7] + (rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25))
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + RoundK[rnd_q] + wcur;
	assign t2 = (rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22))
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ret_q <= ST_IDLE;
			for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
			len_q <= '0;
			fill_q <= '0;
			ovalid_q <= 1'b0;
			olast_q <= 1'b0;
			oi_q <= '0;
			bi_q <= '0;
			rnd_q <= '0;
			cnt_q <= '0;
			last_q <= 1'b0;
			pad_first_q <= 1'b0;
			extra_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						word_q <= in_item.data;
						cnt_q <= (in_item.count > 3'd4) ? 3'd4 : in_item.count;
						last_q <= in_item.last;
						bi_q <= '0;
						state_q <= ST_BYTES;
					end
				end
				ST_BYTES: begin
					// one message byte a cycle; full block starts compression
					if (bi_q == cnt_q) begin
						if (last_q) begin
							pad_first_q <= 1'b1;
							extra_q <= (fill_q > PadLimit);
							state_q <= ST_PAD;
						end else begin
							state_q <= ST_IDLE;
						end
					end else begin
						buf_q[bidx] <= (buf_q[bidx] & ~(32'hff << bsh))
							| ({24'd0, cur_byte} << bsh);
						len_q <= len_q + 64'd8;
						fill_q <= fill_q + 1'b1;
						bi_q <= bi_q + 1'b1;
						if (fill_q == 6'd63) begin
							for (int i = 0; i < 16; i++) w_q[i] <= buf_q[i];
							w_q[bidx] <= (buf_q[bidx] & ~(32'hff << bsh))
								| ({24'd0, cur_byte} << bsh);
							for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
							rnd_q <= '0;
							ret_q <= ST_BYTES;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_PAD: begin
					// 0x80 then zeros, byte-wise; length words close the block
					if (!pad_first_q && !extra_q && fill_q == 6'd56) begin
						for (int i = 0; i < 14; i++) w_q[i] <= buf_q[i];
						w_q[14] <= len_q[63:32];
						w_q[15] <= len_q[31:0];
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
						rnd_q <= '0;
						ret_q <= ST_FINISH;
						state_q <= ST_ROUND;
					end else begin
						buf_q[bidx] <= (buf_q[bidx] & ~(32'hff << bsh))
							| ({24'd0, (pad_first_q ? PadByte : 8'h00)} << bsh);
						pad_first_q <= 1'b0;
						fill_q <= fill_q + 1'b1;
						if (fill_q == 6'd63) begin
							extra_q <= 1'b0;
							for (int i = 0; i < 16; i++) w_q[i] <= buf_q[i];
							w_q[bidx] <= (buf_q[bidx] & ~(32'hff << bsh))
								| ({24'd0, (pad_first_q ? PadByte : 8'h00)} << bsh);
							for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
							rnd_q <= '0;
							ret_q <= ST_PAD;
							state_q <= ST_ROUND;
						end
					end
				end
				ST_ROUND: begin
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wn;
					v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
					v_q[4] <= v_q[3] + t1;
					v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 1'b1;
					if (rnd_q == 6'd63) state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (ret_q == ST_FINISH) begin
						oi_q <= '0;
						state_q <= ST_OUT;
					end else begin
						state_q <= ret_q;
					end
				end
				ST_OUT: begin
					if (!ovalid_q || out_ready) begin
						ow_q <= h_q[oi_q];
						olast_q <= (oi_q == 3'd7);
						ovalid_q <= 1'b1;
						oi_q <= oi_q + 1'b1;
						if (oi_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= InitH[i];
							len_q <= '0;
							fill_q <= '0;
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (ovalid_q && out_ready && !(state_q == ST_OUT)) ovalid_q <= 1'b0;
		end
	end
endmodule
`default_nettype wire

### hdl/sha256_message_hasher.sv
// SHA-256 message hasher top level: input front end, item queue, compression core.
// Depends on sha_pkg, sha_fifo and sha_core.
//
// Words arrive big-endian with a byte count (0..4, larger values count as 4)
// and a last flag. The front end classifies each transaction into an item
// and queues it; the core packs one byte a cycle, except while a full block
// is compressed, and runs one SHA-256 round a cycle. For each word the core
// takes it from the queue, packs its bytes and closes the word; a completed
// 64-byte block costs 64 rounds and the chaining update. Sustained speed is
// limited by the byte packer and the single round unit. On the last word the
// core pads one byte a cycle, may compress one extra block, and emits H0..H7
// as eight output transactions, tlast on H7. The queue lets further words be
// taken while the core works.
`default_nettype none
module sha256_message_hasher
	import sha_pkg::*;
#(
	parameter int FifoDepth = FifoDepthDef
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // data_word[31:0], byte_count[34:32], zeros
	input  wire         s_tlast,  // last_item
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [31:0] m_tdata,  // digest_word
	output logic        m_tlast   // last_word
);
	item_t in_item, q_item;
	logic q_valid, q_ready;

	// classify the transaction into an item for the queue
	assign in_item.data  = s_tdata[31:0];
	assign in_item.count = s_tdata[34:32];
	assign in_item.last  = s_tlast;

	sha_fifo #(.Depth(FifoDepth)) u_fifo (
		.clk, .arst_n,
		.wr_valid(s_tvalid), .wr_ready(s_tready), .wr_item(in_item),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
	);

	sha_core u_core (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.out_word(m_tdata), .out_last(m_tlast)
	);

	// hold payload while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed under stall");

	// keep the handshake lines known out of reset
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({m_tvalid, s_tready}))
		else $error("handshake line unknown");
endmodule
`default_nettype wire
